@@ hw/rtl/smm_pkg.sv @@
// Shared types, constants and helpers for the square matrix multiply unit.
// Used by smm_seq, smm_mac and square_matrix_multiply_unit; depends on nothing.
package smm_pkg;

   // largest matrix dimension the stores hold
   localparam int MAX_SIZE = 8;

   localparam int IDX_W   = 3;                         // row / column field width
   localparam int SIZE_W  = 4;                         // size register width
   localparam int ELEM_W  = 16;                        // Q1.15 element
   localparam int PROD_W  = 2 * ELEM_W;                // Q2.30 product
   localparam int ACC_W   = 35;                        // Q5.30 dot product
   localparam int DEPTH   = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_W  = $clog2(DEPTH);

   // request kinds
   localparam logic [1:0] KIND_LOAD_A = 2'd0;
   localparam logic [1:0] KIND_LOAD_B = 2'd1;
   localparam logic [1:0] KIND_START  = 2'd2;

   // one multiply-accumulate step as it travels down the pipeline
   typedef struct packed {
      logic             valid;
      logic             first_k;
      logic             last_k;
      logic             last_run;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } ctrl_type;

   // row-major store address
   function automatic logic [ADDR_W-1:0] store_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
      return ADDR_W'(32'(row) * MAX_SIZE + 32'(col));
   endfunction

   // clamp the size register to 1 .. MAX_SIZE and return n-1
   function automatic logic [IDX_W-1:0] last_index(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] n;
      n = size;
      if (n == '0) n = SIZE_W'(1);
      if (n > SIZE_W'(MAX_SIZE)) n = SIZE_W'(MAX_SIZE);
      return IDX_W'(n - SIZE_W'(1));
   endfunction

endpackage

@@ hw/rtl/smm_seq.sv @@
// Loop sequencer of the square matrix multiply unit: walks i, j, k over the
// configured size and issues store addresses and step control. Uses smm_pkg.
module smm_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [smm_pkg::IDX_W-1:0]   last_idx,
   output logic                        busy,
   output logic [smm_pkg::ADDR_W-1:0]  a_addr,
   output logic [smm_pkg::ADDR_W-1:0]  b_addr,
   output smm_pkg::ctrl_type           ctrl
);
   import smm_pkg::*;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic             k_end, j_end, i_end;

   assign k_end = (k_ff == last_ff);
   assign j_end = (j_ff == last_ff);
   assign i_end = (i_ff == last_ff);

   // advance k innermost, then j, then i
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               state_in = ST_RUN;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               last_in  = last_idx;
            end
         end
         ST_RUN: begin
            k_in = k_end ? '0 : k_ff + IDX_W'(1);
            if (k_end) begin
               j_in = j_end ? '0 : j_ff + IDX_W'(1);
               if (j_end) begin
                  i_in = i_ff + IDX_W'(1);
                  if (i_end) state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold state and loop counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      last_ff <= last_in;
   end

   // issue one step per cycle while running
   assign busy          = (state_ff == ST_RUN);
   assign a_addr        = store_addr(i_ff, k_ff);
   assign b_addr        = store_addr(k_ff, j_ff);
   assign ctrl.valid    = (state_ff == ST_RUN);
   assign ctrl.first_k  = (k_ff == '0);
   assign ctrl.last_k   = k_end;
   assign ctrl.last_run = k_end && j_end && i_end;
   assign ctrl.row      = i_ff;
   assign ctrl.col      = j_ff;

endmodule

@@ hw/rtl/smm_mac.sv @@
// Shared multiply-accumulate unit: registered 16x16 product, then a 35-bit
// accumulator that emits one dot product per run of k steps. Uses smm_pkg.
module smm_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [smm_pkg::ELEM_W-1:0] a_val,
   input  logic signed [smm_pkg::ELEM_W-1:0] b_val,
   input  smm_pkg::ctrl_type                 ctrl,
   output logic                              rsp_strobe,
   output logic [smm_pkg::IDX_W-1:0]         rsp_row,
   output logic [smm_pkg::IDX_W-1:0]         rsp_col,
   output logic signed [smm_pkg::ACC_W-1:0]  rsp_value,
   output logic                              rsp_last
);
   import smm_pkg::*;

   logic signed [PROD_W-1:0] a_ext, b_ext;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   ctrl_type                 ctrl_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     strobe_ff;
   logic [IDX_W-1:0]         row_ff, col_ff;
   logic                     last_ff;

   // multiply stage
   assign a_ext   = PROD_W'(a_val);
   assign b_ext   = PROD_W'(b_val);
   assign prod_in = a_ext * b_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl;
      end
      prod_ff <= prod_in;
   end

   // accumulate stage: restart the sum on the first k step
   assign acc_in = ctrl_ff.first_k ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctrl_ff.valid && ctrl_ff.last_k;
      end
      if (ctrl_ff.valid) begin
         acc_ff  <= acc_in;
         row_ff  <= ctrl_ff.row;
         col_ff  <= ctrl_ff.col;
         last_ff <= ctrl_ff.last_run;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_row    = row_ff;
   assign rsp_col    = col_ff;
   assign rsp_value  = acc_ff;
   assign rsp_last   = last_ff;

endmodule

@@ hw/rtl/square_matrix_multiply_unit.sv @@
// Top level of the square matrix multiply unit: A and B stores, size register,
// sequencer and shared MAC. Uses smm_pkg, smm_seq and smm_mac.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. Kind
//   load A / load B writes one element into the A or B store (row-major,
//   indexes at or above MAX_SIZE dropped); load requests give no response.
//   Kind start multiplies the leading n-by-n corners, n = csr size clamped to
//   1 .. MAX_SIZE, and emits n*n responses in row-major order, last one
//   flagged by rsp_last_of_run. Kind 3 is dropped.
//   A start holds busy high while the single MAC takes one k step per cycle;
//   each response passes the store read, product and accumulator registers,
//   so the last response is taken after busy falls.
//   Each response is valid for one cycle on rsp_strobe; the receiver cannot
//   stall, so it must take every strobe.
//   Reset (synchronous) clears busy and the pipeline and sets the size to
//   MAX_SIZE; the stores are undefined until written.
//   Write csr_wr_data via csr_wr_en only while no responses are pending.
module square_matrix_multiply_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_kind,
   input  logic [smm_pkg::IDX_W-1:0]         req_row_index,
   input  logic [smm_pkg::IDX_W-1:0]         req_col_index,
   input  logic signed [smm_pkg::ELEM_W-1:0] req_element_value,
   output logic                              rsp_strobe,
   output logic [smm_pkg::IDX_W-1:0]         rsp_out_row,
   output logic [smm_pkg::IDX_W-1:0]         rsp_out_col,
   output logic signed [smm_pkg::ACC_W-1:0]  rsp_product_value,
   output logic                              rsp_last_of_run,
   input  logic                              csr_wr_en,
   input  logic [smm_pkg::SIZE_W-1:0]        csr_wr_data
);
   import smm_pkg::*;

   logic                     accept;
   logic                     in_range;
   logic [ADDR_W-1:0]        wr_addr;
   logic [SIZE_W-1:0]        size_ff;
   logic [ADDR_W-1:0]        a_addr, b_addr;
   ctrl_type                 seq_ctrl;
   ctrl_type                 rd_ctrl_ff;
   logic signed [ELEM_W-1:0] a_mem [DEPTH];
   logic signed [ELEM_W-1:0] b_mem [DEPTH];
   logic signed [ELEM_W-1:0] a_rd_ff, b_rd_ff;

   assign accept   = start && !busy;
   assign in_range = ({1'b0, req_row_index} < (IDX_W + 1)'(MAX_SIZE)) &&
                     ({1'b0, req_col_index} < (IDX_W + 1)'(MAX_SIZE));
   assign wr_addr  = store_addr(req_row_index, req_col_index);

   // size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(MAX_SIZE);
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   smm_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .go       (accept && (req_kind == KIND_START)),
      .last_idx (last_index(size_ff)),
      .busy     (busy),
      .a_addr   (a_addr),
      .b_addr   (b_addr),
      .ctrl     (seq_ctrl)
   );

   // write the stores on load requests
   always_ff @(posedge clock) begin
      if (accept && in_range && (req_kind == KIND_LOAD_A)) begin
         a_mem[wr_addr] <= req_element_value;
      end
      if (accept && in_range && (req_kind == KIND_LOAD_B)) begin
         b_mem[wr_addr] <= req_element_value;
      end
   end

   // registered store reads, control delayed alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ctrl_ff <= '0;
      end else begin
         rd_ctrl_ff <= seq_ctrl;
      end
      a_rd_ff <= a_mem[a_addr];
      b_rd_ff <= b_mem[b_addr];
   end

   smm_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .a_val      (a_rd_ff),
      .b_val      (b_rd_ff),
      .ctrl       (rd_ctrl_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_row    (rsp_out_row),
      .rsp_col    (rsp_out_col),
      .rsp_value  (rsp_product_value),
      .rsp_last   (rsp_last_of_run)
   );

endmodule

@@ bench/smm_checker.sv @@
// Response checker for the square matrix multiply unit: mirrors the A and B stores
// and the size register, predicts every product of a run and checks the responses.
// Depends on smm_pkg; instantiated by square_matrix_multiply_unit_tb.
module smm_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [1:0]                        req_kind,
   input  logic [smm_pkg::IDX_W-1:0]         req_row_index,
   input  logic [smm_pkg::IDX_W-1:0]         req_col_index,
   input  logic signed [smm_pkg::ELEM_W-1:0] req_element_value,
   input  logic                              rsp_strobe,
   input  logic [smm_pkg::IDX_W-1:0]         rsp_out_row,
   input  logic [smm_pkg::IDX_W-1:0]         rsp_out_col,
   input  logic signed [smm_pkg::ACC_W-1:0]  rsp_product_value,
   input  logic                              rsp_last_of_run,
   input  logic                              csr_wr_en,
   input  logic [smm_pkg::SIZE_W-1:0]        csr_wr_data,
   output int                                mismatch_count,
   output int                                products_pending,
   output int                                products_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import smm_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [ACC_W-1:0] value;
      logic                    last;
   } product_type;

   product_type              expected_products[$];
   logic signed [ELEM_W-1:0] a_mirror[DEPTH];
   logic signed [ELEM_W-1:0] b_mirror[DEPTH];
   logic [SIZE_W-1:0]        size_mirror;

   always @(posedge clock) begin : watch
      product_type got;
      product_type want;
      int          n;
      int          i;
      int          j;
      int          k;
      int          addr;
      longint      acc;

      if (reset) begin
         size_mirror = SIZE_W'(MAX_SIZE);
         expected_products.delete();
         mismatch_count = 0;
         products_checked = 0;
         products_pending <= 0;
      end else begin
         // compare the response against the oldest predicted product
         if (rsp_strobe === 1'b1) begin
            got = '{rsp_out_row, rsp_out_col, rsp_product_value, rsp_last_of_run};
            if (expected_products.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t smm_checker: response (%0d,%0d) value %0d last %0b %s",
                           $time, got.row, got.col, $signed(got.value), got.last,
                           "with none pending");
               mismatch_count++;
            end else begin
               want = expected_products.pop_front();
               products_checked++;
               if (got !== want) begin
                  if (mismatch_count < 10)
                     $display({"%0t smm_checker: expected (%0d,%0d) %0d last %0b, ",
                               "got (%0d,%0d) %0d last %0b"},
                              $time, want.row, want.col, $signed(want.value), want.last,
                              got.row, got.col, $signed(got.value), got.last);
                  mismatch_count++;
               end
            end
         end

         // apply the accepted request to the mirror, or predict a whole run
         if (start === 1'b1 && busy === 1'b0) begin
            addr = int'(req_row_index) * MAX_SIZE + int'(req_col_index);
            case (req_kind)
               KIND_LOAD_A: a_mirror[addr] = req_element_value;
               KIND_LOAD_B: b_mirror[addr] = req_element_value;
               KIND_START: begin
                  n = int'(size_mirror);
                  if (n == 0) n = 1;
                  if (n > MAX_SIZE) n = MAX_SIZE;
                  for (i = 0; i < n; i++) begin
                     for (j = 0; j < n; j++) begin
                        acc = 0;
                        for (k = 0; k < n; k++)
                           acc += longint'(a_mirror[i * MAX_SIZE + k]) *
                                  longint'(b_mirror[k * MAX_SIZE + j]);
                        want.row = IDX_W'(i);
                        want.col = IDX_W'(j);
                        want.value = ACC_W'(acc);
                        want.last = (i == n - 1) && (j == n - 1);
                        expected_products.push_back(want);
                     end
                  end
               end
               default: ;
            endcase
         end

         // a size write takes effect for requests after this edge
         if (csr_wr_en === 1'b1)
            size_mirror = csr_wr_data;

         products_pending <= expected_products.size();
      end
   end

endmodule

@@ bench/square_matrix_multiply_unit_tb.sv @@
// Top of the square matrix multiply unit testbench: clock, reset and request stimulus.
// Depends on smm_pkg, square_matrix_multiply_unit and smm_checker, which does the checking.
module square_matrix_multiply_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import smm_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int PHASES = 10;
   localparam int ITEMS_PER_PHASE = 35;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_kind = KIND_LOAD_A;
   logic [IDX_W-1:0]         req_row_index = '0;
   logic [IDX_W-1:0]         req_col_index = '0;
   logic signed [ELEM_W-1:0] req_element_value = '0;
   logic                     rsp_strobe;
   logic [IDX_W-1:0]         rsp_out_row;
   logic [IDX_W-1:0]         rsp_out_col;
   logic signed [ACC_W-1:0]  rsp_product_value;
   logic                     rsp_last_of_run;
   logic                     csr_wr_en = 1'b0;
   logic [SIZE_W-1:0]        csr_wr_data = '0;

   int mismatch_count;
   int products_pending;
   int products_checked;

   // stimulus bookkeeping: which store entries hold a value, and what was sent
   bit                written_a[DEPTH];
   bit                written_b[DEPTH];
   logic [SIZE_W-1:0] size_setting = SIZE_W'(MAX_SIZE);
   int                load_count;
   int                start_count;
   int                ignored_count;
   int                size_writes;
   bit                no_idle;

   logic [SIZE_W-1:0] phase_sizes[PHASES] =
      '{4'd3, 4'd15, 4'd2, 4'd8, 4'd5, 4'd9, 4'd1, 4'd7, 4'd0, 4'd4};

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   square_matrix_multiply_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   smm_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .mismatch_count    (mismatch_count),
      .products_pending  (products_pending),
      .products_checked  (products_checked)
   );

   // dimension the block uses for a given size register value
   function automatic int corner_size(input logic [SIZE_W-1:0] setting);
      int n;
      n = int'(setting);
      if (n == 0) n = 1;
      if (n > MAX_SIZE) n = MAX_SIZE;
      return n;
   endfunction

   // element value: a corner value with the given percent chance, else fully random
   function automatic logic signed [ELEM_W-1:0] pick_value(input int bias);
      logic signed [ELEM_W-1:0] corners[5] =
         '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};
      if ($urandom_range(0, 99) < bias)
         return corners[$urandom_range(0, 4)];
      return ELEM_W'($urandom);
   endfunction

   // drop start and hold off for a number of cycles
   task automatic pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // mostly short gaps, a few long ones, none during a burst
   task automatic idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return;
      if (r < 92) pause($urandom_range(1, 3));
      else pause($urandom_range(10, 40));
   endtask

   // present one request and hold it until the block takes it
   task automatic send(input logic [1:0] kind, input int row, input int col,
                       input logic signed [ELEM_W-1:0] value);
      req_kind <= kind;
      req_row_index <= IDX_W'(row);
      req_col_index <= IDX_W'(col);
      req_element_value <= value;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      case (kind)
         KIND_LOAD_A: begin
            written_a[row * MAX_SIZE + col] = 1'b1;
            load_count++;
         end
         KIND_LOAD_B: begin
            written_b[row * MAX_SIZE + col] = 1'b1;
            load_count++;
         end
         KIND_START: start_count++;
         default: ignored_count++;
      endcase
      idle_gap();
   endtask

   // load every entry of the active corner that was never written, then start
   task automatic run_product(input int bias);
      int n;
      n = corner_size(size_setting);
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++) begin
            if (!written_a[r * MAX_SIZE + c]) send(KIND_LOAD_A, r, c, pick_value(bias));
            if (!written_b[r * MAX_SIZE + c]) send(KIND_LOAD_B, r, c, pick_value(bias));
         end
      send(KIND_START, $urandom_range(0, 7), $urandom_range(0, 7), ELEM_W'($urandom));
   endtask

   // wait for every pending product and let the pipeline drain, then write the size
   task automatic set_size(input logic [SIZE_W-1:0] setting);
      pause(1);
      while (products_pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= setting;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      size_setting = setting;
      size_writes++;
   endtask

   initial begin : stimulus
      int directed_items;
      int target;
      int n;
      int r;
      int bias;

      no_idle = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single element: most negative squared, mixed signs, ignored kind
      set_size(4'd1);
      send(KIND_LOAD_A, 0, 0, 16'sh8000);
      send(KIND_LOAD_B, 0, 0, 16'sh8000);
      send(KIND_START, 0, 0, 16'sh0000);
      send(KIND_LOAD_B, 0, 0, 16'sh7fff);
      send(KIND_START, 7, 7, 16'sh7fff);
      send(KIND_UNUSED, 0, 0, 16'sh1234);
      send(KIND_START, 0, 0, 16'sh0000);
      send(KIND_LOAD_A, 0, 0, 16'sh7fff);
      send(KIND_LOAD_A, 7, 7, 16'shffff);
      send(KIND_LOAD_B, 7, 0, 16'sh8000);
      send(KIND_START, 3, 5, 16'sh5a5a);

      // size zero acts as one
      set_size(4'd0);
      send(KIND_START, 0, 0, 16'shffff);

      // two by two with corner values, back-to-back starts
      set_size(4'd2);
      run_product(100);
      send(KIND_START, 0, 0, 16'sh0000);
      directed_items = load_count + start_count;

      // random phases, each at its own size setting
      for (int p = 0; p < PHASES; p++) begin
         set_size(phase_sizes[p]);
         no_idle = ($urandom_range(0, 3) == 0);
         bias = (p == 1) ? 100 : 20;
         target = directed_items + ITEMS_PER_PHASE * (p + 1);
         do begin
            n = corner_size(size_setting);
            r = $urandom_range(0, 99);
            if (r < 55)
               send($urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A,
                    $urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_value(bias));
            else if (r < 70)
               run_product(bias);
            else if (r < 75)
               send(KIND_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                    ELEM_W'($urandom));
            else
               send($urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A,
                    $urandom_range(0, 7), $urandom_range(0, 7), pick_value(bias));
         end while (load_count + start_count < target);
         run_product(bias);
      end

      // drain and give the verdict
      pause(1);
      while (products_pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Sent %0d loads, %0d starts and %0d ignored requests over %0d size settings;",
               load_count, start_count, ignored_count, size_writes);
      $display("compared %0d product elements, %0d mismatches.",
               products_checked, mismatch_count);
      if (mismatch_count == 0 && products_pending == 0)
         $display("square_matrix_multiply_unit_tb: clean");
      else
         $display("square_matrix_multiply_unit_tb: errors");
      $finish;
   end

   initial begin : watchdog
      #20ms;
      $display("square_matrix_multiply_unit_tb: errors");
      $finish;
   end

endmodule
